// ----- rtl/lqm_pkg.sv -----
// Package: sizes, codes and sequencer states of the linked queue manager.
`timescale 1ns / 1ps
package lqm_pkg;

	localparam int NUM_ELEMENTS = 16;
	localparam int NUM_QUEUES   = 4;

	localparam int OP_W    = 2;
	localparam int QUEUE_W = 2;
	localparam int ELEM_W  = 4;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	typedef logic [OP_W-1:0]    op_bits_t;
	typedef logic [QUEUE_W-1:0] queue_t;
	typedef logic [ELEM_W-1:0]  elem_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_QUEUED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_LINK,
		S_LINK2,
		S_DONE
	} state_t;

endpackage

// ----- rtl/linked_queue_manager_top.sv -----
// Top level: circular doubly linked queue manager with link tables and request sequencer.
//
// Usage:
//  Input channel (in_valid / in_stall) carries one request per beat: operation,
//  queue_id and element. Output channel (out_valid / out_stall) returns exactly
//  one result beat per request: status, element_out, queue_length, head_element
//  and is_empty, describing the addressed queue after the request.
//  Sequence: the request is accepted in the idle step, checked, and the result
//  register is loaded in the final step; a remove that relinks neighbors adds a
//  link step before it, and an append to a nonempty queue adds a link step and
//  a second link step. A new request is accepted only after the return to idle.
//  The next/prev link tables each have one write port, so the two pairs of link
//  writes of an append go in two steps.
//  in_stall is high while a request is in flight; one request at a time.
//  The finished result sits in an output register; the sequencer waits in its
//  final step while a previous result is stalled, then returns to idle.
//  Reset (arst_n low) empties every queue, clears the linked flags and drops
//  out_valid. Link tables and owner tags are not cleared; they are only read
//  for elements that were linked.
`timescale 1ns / 1ps
module linked_queue_manager_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lqm_pkg::OP_W-1:0]    operation,
	input  logic [lqm_pkg::QUEUE_W-1:0] queue_id,
	input  logic [lqm_pkg::ELEM_W-1:0]  element,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lqm_pkg::STAT_W-1:0]  status,
	output logic [lqm_pkg::ELEM_W-1:0]  element_out,
	output logic [lqm_pkg::COUNT_W-1:0] queue_length,
	output logic [lqm_pkg::ELEM_W-1:0]  head_element,
	output logic                       is_empty
);

	localparam logic [lqm_pkg::QUEUE_W:0] QUEUE_LIMIT =
		(lqm_pkg::QUEUE_W+1)'(lqm_pkg::NUM_QUEUES);
	localparam logic [lqm_pkg::ELEM_W:0]  ELEM_LIMIT  =
		(lqm_pkg::ELEM_W+1)'(lqm_pkg::NUM_ELEMENTS);

	lqm_pkg::state_t  state_q, state_d;
	lqm_pkg::op_bits_t op_q;
	lqm_pkg::queue_t   qid_q;
	lqm_pkg::elem_t    elem_q;
	lqm_pkg::status_t  status_q;

	lqm_pkg::elem_t  head_q  [lqm_pkg::NUM_QUEUES];
	lqm_pkg::count_t count_q [lqm_pkg::NUM_QUEUES];
	logic [lqm_pkg::NUM_ELEMENTS-1:0] linked_q;
	lqm_pkg::queue_t owner_q [lqm_pkg::NUM_ELEMENTS];

	lqm_pkg::elem_t next_mem [lqm_pkg::NUM_ELEMENTS];
	lqm_pkg::elem_t prev_mem [lqm_pkg::NUM_ELEMENTS];
	lqm_pkg::elem_t next_rd_q, prev_rd_q;

	logic           rd_en;
	lqm_pkg::elem_t prev_raddr;
	logic           next_we, prev_we;
	lqm_pkg::elem_t next_waddr, next_wdata, prev_waddr, prev_wdata;
	logic           out_free;
	logic           out_load;

	logic              q_ok, e_ok;
	lqm_pkg::count_t   cur_cnt;
	lqm_pkg::elem_t    cur_head;
	logic              cur_linked;
	logic              do_append, do_remove, link_needed;
	lqm_pkg::status_t  chk_status;
	lqm_pkg::count_t   res_len;
	lqm_pkg::elem_t    res_head;

	logic                          out_valid_q;
	lqm_pkg::status_t              out_status_q;
	lqm_pkg::elem_t                out_elem_q;
	lqm_pkg::count_t               out_len_q;
	lqm_pkg::elem_t                out_head_q;
	logic                          out_empty_q;

	// request decode against queue and element bookkeeping
	always_comb begin
		q_ok       = {1'b0, qid_q} < QUEUE_LIMIT;
		e_ok       = {1'b0, elem_q} < ELEM_LIMIT;
		cur_cnt    = count_q[qid_q];
		cur_head   = head_q[qid_q];
		cur_linked = linked_q[elem_q];
		do_append  = 1'b0;
		do_remove  = 1'b0;
		chk_status = lqm_pkg::ST_OK;
		if (!q_ok) begin
			if (op_q == lqm_pkg::OP_APPEND || op_q == lqm_pkg::OP_REMOVE)
				chk_status = lqm_pkg::ST_EMPTY;
		end else if (op_q == lqm_pkg::OP_APPEND) begin
			if (!e_ok)
				chk_status = lqm_pkg::ST_ABSENT;
			else if (cur_linked)
				chk_status = lqm_pkg::ST_QUEUED;
			else
				do_append = 1'b1;
		end else if (op_q == lqm_pkg::OP_REMOVE) begin
			if (cur_cnt == '0)
				chk_status = lqm_pkg::ST_EMPTY;
			else if (!e_ok || !cur_linked || owner_q[elem_q] != qid_q)
				chk_status = lqm_pkg::ST_ABSENT;
			else
				do_remove = 1'b1;
		end
		link_needed = (do_append && cur_cnt != '0) ||
			(do_remove && cur_cnt > lqm_pkg::COUNT_W'(1));
		res_len  = q_ok ? cur_cnt : '0;
		res_head = (res_len != '0) ? cur_head : '0;
	end

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lqm_pkg::S_IDLE:  if (in_valid) state_d = lqm_pkg::S_CHECK;
			lqm_pkg::S_CHECK: state_d = link_needed ? lqm_pkg::S_LINK : lqm_pkg::S_DONE;
			lqm_pkg::S_LINK: begin
				if (op_q == lqm_pkg::OP_APPEND)
					state_d = lqm_pkg::S_LINK2;
				else
					state_d = lqm_pkg::S_DONE;
			end
			lqm_pkg::S_LINK2: state_d = lqm_pkg::S_DONE;
			lqm_pkg::S_DONE:  if (out_free) state_d = lqm_pkg::S_IDLE;
			default:          state_d = lqm_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: link table ports and handshakes
	always_comb begin
		in_stall   = 1'b1;
		rd_en      = 1'b0;
		prev_raddr = elem_q;
		next_we    = 1'b0;
		prev_we    = 1'b0;
		next_waddr = elem_q;
		next_wdata = elem_q;
		prev_waddr = elem_q;
		prev_wdata = elem_q;
		out_load   = 1'b0;
		case (state_q)
			lqm_pkg::S_IDLE: in_stall = 1'b0;
			lqm_pkg::S_CHECK: begin
				rd_en = 1'b1;
				if (do_append)
					prev_raddr = cur_head;
				if (do_append && cur_cnt == '0) begin
					next_we = 1'b1;
					prev_we = 1'b1;
				end
			end
			lqm_pkg::S_LINK: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				if (op_q == lqm_pkg::OP_APPEND) begin
					// tail.next = e, e.prev = tail
					next_waddr = prev_rd_q;
					next_wdata = elem_q;
					prev_waddr = elem_q;
					prev_wdata = prev_rd_q;
				end else begin
					// p.next = n, n.prev = p
					next_waddr = prev_rd_q;
					next_wdata = next_rd_q;
					prev_waddr = next_rd_q;
					prev_wdata = prev_rd_q;
				end
			end
			lqm_pkg::S_LINK2: begin
				// e.next = head, head.prev = e
				next_we    = 1'b1;
				prev_we    = 1'b1;
				next_waddr = elem_q;
				next_wdata = cur_head;
				prev_waddr = cur_head;
				prev_wdata = elem_q;
			end
			lqm_pkg::S_DONE: out_load = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	// link tables
	always_ff @(posedge clk) begin
		if (next_we)
			next_mem[next_waddr] <= next_wdata;
		if (prev_we)
			prev_mem[prev_waddr] <= prev_wdata;
		if (rd_en) begin
			next_rd_q <= next_mem[elem_q];
			prev_rd_q <= prev_mem[prev_raddr];
		end
	end

	// owner tags, request payload, check status and result register
	always_ff @(posedge clk) begin
		if (state_q == lqm_pkg::S_IDLE && in_valid) begin
			op_q   <= operation;
			qid_q  <= queue_id;
			elem_q <= element;
		end
		if (state_q == lqm_pkg::S_CHECK) begin
			status_q <= chk_status;
			if (do_append)
				owner_q[elem_q] <= qid_q;
		end
		if (out_load) begin
			out_status_q <= status_q;
			out_elem_q   <= elem_q;
			out_len_q    <= res_len;
			out_head_q   <= res_head;
			out_empty_q  <= (res_len == '0);
		end
	end

	// control state, queue bookkeeping and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lqm_pkg::S_IDLE;
			head_q      <= '{default: '0};
			count_q     <= '{default: '0};
			linked_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lqm_pkg::S_CHECK) begin
				if (do_append) begin
					linked_q[elem_q] <= 1'b1;
					count_q[qid_q]   <= cur_cnt + lqm_pkg::COUNT_W'(1);
					if (cur_cnt == '0)
						head_q[qid_q] <= elem_q;
				end
				if (do_remove) begin
					linked_q[elem_q] <= 1'b0;
					count_q[qid_q]   <= cur_cnt - lqm_pkg::COUNT_W'(1);
				end
			end
			if (state_q == lqm_pkg::S_LINK && op_q == lqm_pkg::OP_REMOVE &&
				cur_head == elem_q)
				head_q[qid_q] <= next_rd_q;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign element_out  = out_elem_q;
	assign queue_length = out_len_q;
	assign head_element = out_head_q;
	assign is_empty     = out_empty_q;

	// total of queue counters must match the linked flags
	logic [lqm_pkg::COUNT_W+lqm_pkg::QUEUE_W-1:0] count_total;
	always_comb begin
		count_total = '0;
		for (int i = 0; i < lqm_pkg::NUM_QUEUES; i++)
			count_total = count_total + (lqm_pkg::COUNT_W+lqm_pkg::QUEUE_W)'(count_q[i]);
	end

	a_count_matches_linked: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(linked_q) == int'(count_total))
		else $error("queue counters disagree with linked flags");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != lqm_pkg::S_IDLE |->
			count_q[qid_q] <= lqm_pkg::COUNT_W'(lqm_pkg::NUM_ELEMENTS))
		else $error("queue counter above pool size");

	a_remove_unlinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lqm_pkg::S_CHECK && do_remove) |=> !linked_q[elem_q])
		else $error("removed element still linked");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == lqm_pkg::S_DONE)
		else $error("result beat raised outside final step");

	a_one_result_per_request: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lqm_pkg::S_DONE && out_free) |=> (out_valid_q && state_q == lqm_pkg::S_IDLE))
		else $error("result not delivered at end of request");

endmodule
